FILE: sv/afu_pkg.sv
// ----------------------------------------------------------------------------
// afu_pkg: shared types, codes and tables of the activation function unit
// Holds the activation kind and operation codes, the control struct that
// travels down the pipeline, the sigmoid and exponential tables built at
// elaboration time, and the output saturation function.
// ----------------------------------------------------------------------------
package afu_pkg;

  localparam int unsigned XW   = 16;
  localparam int unsigned TW   = 13;
  localparam int unsigned FW   = 7;
  localparam int unsigned IW   = 9;
  localparam int unsigned TLEN = 257;
  localparam int unsigned PW   = 30;
  localparam int unsigned RW   = 18;
  localparam int unsigned EW   = 19;

  localparam logic [2:0] KIND_RELU    = 3'd0;
  localparam logic [2:0] KIND_SIGMOID = 3'd1;
  localparam logic [2:0] KIND_ELU     = 3'd2;
  localparam logic [2:0] KIND_LEAKY   = 3'd3;
  localparam logic [2:0] KIND_RELU6   = 3'd4;

  localparam logic OP_FUNC  = 1'b0;
  localparam logic OP_DERIV = 1'b1;

  localparam logic [1:0] REG_KIND        = 2'd0;
  localparam logic [1:0] REG_ELU_ALPHA   = 2'd1;
  localparam logic [1:0] REG_LEAKY_ALPHA = 2'd2;

  localparam logic [12:0] ONE_Q         = 13'd4096;
  localparam logic signed [XW-1:0] SIX_Q = 16'sd24576;

  typedef logic [TW-1:0] tab_t [0:TLEN-1];

  typedef struct packed {
    logic                 op;
    logic signed [XW-1:0] x;
    logic [XW-1:0]        mag;
  } ctrl_t;

  // Shift-and-subtract quotient, valid when the quotient fits in qbits bits.
  function automatic logic [63:0] div_fx(input logic [63:0] num, input logic [63:0] den,
                                         input int qbits);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = {1'b0, num >> qbits};
    quo = '0;
    for (int b = qbits - 1; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Tables follow a fixed-point series for exp(-1/32), raised step by step.
  function automatic tab_t build_tab(input logic sel_exp);
    tab_t          tab;
    logic [63:0]   fix_one;
    logic [63:0]   step;
    logic [63:0]   term;
    logic [63:0]   e;
    logic [63:0]   d;
    logic [63:0]   v;
    logic [127:0]  p;
    fix_one = 64'd1 << 62;
    step    = fix_one;
    term    = fix_one;
    e       = fix_one;
    for (int n = 1; n <= 16; n++) begin
      term = div_fx(term, 64'd32 * 64'(n), 64);
      if ((n % 2) == 1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    for (int i = 0; i < TLEN; i++) begin
      d = (fix_one + e) >> 22;
      if (sel_exp) begin
        v = (e + (64'd1 << 49)) >> 50;
      end else begin
        v = div_fx((64'd1 << 52) + (d >> 1), d, 14);
      end
      tab[i] = v[TW-1:0];
      p = {64'd0, e} * {64'd0, step};
      e = p[125:62];
    end
    return tab;
  endfunction

  localparam tab_t SIG_TAB = build_tab(1'b0);
  localparam tab_t EXP_TAB = build_tab(1'b1);

  function automatic logic signed [XW-1:0] sat16(input logic signed [EW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/afu_lookup.sv
// ----------------------------------------------------------------------------
// afu_lookup: first pipeline stage
// Takes the magnitude of x, splits it into table index and fraction, and
// registers the two neighboring table entries of the selected table.
// ----------------------------------------------------------------------------
module afu_lookup (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [2:0]                     kind_i,
  input  logic                           valid_i,
  input  logic                           op_i,
  input  logic signed [afu_pkg::XW-1:0]  x_i,
  output logic                           valid_o,
  output afu_pkg::ctrl_t                 ctrl_o,
  output logic [afu_pkg::TW-1:0]         t0_o,
  output logic [afu_pkg::TW-1:0]         t1_o,
  output logic [afu_pkg::FW-1:0]         frac_o
);
  import afu_pkg::*;

  logic [XW-1:0] mag;
  logic [IW-1:0] idx0;
  logic [IW-1:0] idx1;
  logic [TW-1:0] t0_d;
  logic [TW-1:0] t1_d;
  logic          valid_q;
  ctrl_t         ctrl_q;
  logic [TW-1:0] t0_q;
  logic [TW-1:0] t1_q;
  logic [FW-1:0] frac_q;

  always_comb begin
    mag  = x_i[XW-1] ? (~x_i + 16'd1) : x_i;
    idx0 = mag[XW-1:FW];
    idx1 = (idx0 == IW'(TLEN - 1)) ? idx0 : idx0 + 9'd1;
    if (kind_i == KIND_ELU) begin
      t0_d = EXP_TAB[idx0];
      t1_d = EXP_TAB[idx1];
    end else begin
      t0_d = SIG_TAB[idx0];
      t1_d = SIG_TAB[idx1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q <= '{op: op_i, x: x_i, mag: mag};
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    frac_q <= mag[FW-1:0];
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign t0_o    = t0_q;
  assign t1_o    = t1_q;
  assign frac_o  = frac_q;

endmodule

FILE: sv/afu_interp.sv
// ----------------------------------------------------------------------------
// afu_interp: second pipeline stage
// Linear interpolation between two table entries with a 7-bit fraction,
// rounded to nearest.
// ----------------------------------------------------------------------------
module afu_interp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  afu_pkg::ctrl_t          ctrl_i,
  input  logic [afu_pkg::TW-1:0]  t0_i,
  input  logic [afu_pkg::TW-1:0]  t1_i,
  input  logic [afu_pkg::FW-1:0]  frac_i,
  output logic                    valid_o,
  output afu_pkg::ctrl_t          ctrl_o,
  output logic [afu_pkg::TW-1:0]  v_o
);
  import afu_pkg::*;

  logic [FW:0]      wt0;
  logic [TW+FW+1:0] acc;
  logic [TW-1:0]    v_d;
  logic             valid_q;
  ctrl_t            ctrl_q;
  logic [TW-1:0]    v_q;

  always_comb begin
    wt0 = 8'd128 - {1'b0, frac_i};
    acc = 21'(t0_i) * 21'(wt0) + 21'(t1_i) * 21'(frac_i) + 21'd64;
    v_d = acc[TW+FW-1:FW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q <= ctrl_i;
    v_q    <= v_d;
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign v_o     = v_q;

endmodule

FILE: sv/afu_finish.sv
// ----------------------------------------------------------------------------
// afu_finish: third and fourth pipeline stages
// Registers one scaling product, then rounds it, applies the per-kind
// selection and sign, and saturates the result to 16 bits.
// ----------------------------------------------------------------------------
module afu_finish (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [2:0]                     kind_i,
  input  logic [12:0]                    elu_alpha_i,
  input  logic [12:0]                    leaky_alpha_i,
  input  logic                           valid_i,
  input  afu_pkg::ctrl_t                 ctrl_i,
  input  logic [afu_pkg::TW-1:0]         v_i,
  output logic                           valid_o,
  output logic signed [afu_pkg::XW-1:0]  y_o
);
  import afu_pkg::*;

  logic [12:0]          mul_a;
  logic [XW:0]          mul_b;
  logic                 valid3_q;
  ctrl_t                ctrl3_q;
  logic [TW-1:0]        v3_q;
  logic [PW-1:0]        prod_q;
  logic [PW-1:0]        rnd;
  logic signed [EW-1:0] r_s;
  logic signed [EW-1:0] x_s;
  logic signed [EW-1:0] res;
  logic                 neg;
  logic                 pos;
  logic                 valid4_q;
  logic signed [XW-1:0] y_q;

  always_comb begin
    mul_a = v_i;
    mul_b = 17'(ONE_Q - v_i);
    case (kind_i)
      KIND_ELU: begin
        mul_a = elu_alpha_i;
        mul_b = (ctrl_i.op == OP_DERIV) ? 17'(v_i) : 17'(ONE_Q - v_i);
      end
      KIND_LEAKY: begin
        mul_a = leaky_alpha_i;
        mul_b = 17'(ctrl_i.mag);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl3_q <= ctrl_i;
    v3_q    <= v_i;
    prod_q  <= PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    rnd = prod_q + 30'd2048;
    r_s = $signed({1'b0, rnd[PW-1:PW-RW]});
    x_s = EW'(ctrl3_q.x);
    neg = ctrl3_q.x[XW-1];
    pos = !neg && (ctrl3_q.x != '0);
    res = '0;
    case (kind_i)
      KIND_RELU: begin
        if (ctrl3_q.op == OP_DERIV) res = pos ? EW'(ONE_Q) : '0;
        else                        res = pos ? x_s : '0;
      end
      KIND_SIGMOID: begin
        if (ctrl3_q.op == OP_DERIV) res = r_s;
        else res = neg ? EW'(ONE_Q - v3_q) : EW'(v3_q);
      end
      KIND_ELU: begin
        if (!neg)                        res = (ctrl3_q.op == OP_DERIV) ? EW'(ONE_Q) : x_s;
        else if (ctrl3_q.op == OP_DERIV) res = r_s;
        else                             res = -r_s;
      end
      KIND_LEAKY: begin
        if (ctrl3_q.op == OP_DERIV) res = pos ? EW'(ONE_Q) : EW'(leaky_alpha_i);
        else                        res = neg ? -r_s : x_s;
      end
      KIND_RELU6: begin
        if (ctrl3_q.op == OP_DERIV) res = (pos && ctrl3_q.x < SIX_Q) ? EW'(ONE_Q) : '0;
        else if (!pos)              res = '0;
        else                        res = (ctrl3_q.x >= SIX_Q) ? EW'(SIX_Q) : x_s;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    y_q <= sat16(res);
  end

  assign valid_o = valid4_q;
  assign y_o     = y_q;

endmodule

FILE: sv/activation_function_unit.sv
// ----------------------------------------------------------------------------
// activation_function_unit: pipelined Q4.12 activation functions
// ReLU, sigmoid, ELU, leaky ReLU and ReLU6, function value or derivative.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is accepted at a clock edge where start is high and busy is
// low. Busy never rises, so one transaction can be issued every cycle.
// The result is on y_o with y_valid_o high for exactly one cycle, once the
// transaction has passed through the four register stages.
// The four register stages are table
// lookup, interpolation, scaling multiply and round/saturate; throughput is
// one result per cycle. The receiver cannot stall; every result must be
// taken in its cycle.
// Configuration writes use cfg_valid_i/cfg_ready_o with a register index
// (0 kind, 1 ELU alpha, 2 leaky alpha); other indexes are ignored. Writes
// are always accepted and should be made only while the pipeline is empty.
// Reset clears the pipeline valid bits and loads kind ReLU, ELU alpha 1.0
// and leaky alpha 41.
// ----------------------------------------------------------------------------
module activation_function_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic signed [afu_pkg::XW-1:0]  x_i,
  output logic                           y_valid_o,
  output logic signed [afu_pkg::XW-1:0]  y_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [12:0]                    cfg_data_i
);
  import afu_pkg::*;

  logic [2:0]    kind_q;
  logic [12:0]   elu_alpha_q;
  logic [12:0]   leaky_alpha_q;
  logic          s1_valid;
  ctrl_t         s1_ctrl;
  logic [TW-1:0] s1_t0;
  logic [TW-1:0] s1_t1;
  logic [FW-1:0] s1_frac;
  logic          s2_valid;
  ctrl_t         s2_ctrl;
  logic [TW-1:0] s2_v;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q        <= KIND_RELU;
      elu_alpha_q   <= 13'd4096;
      leaky_alpha_q <= 13'd41;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_KIND:        kind_q        <= cfg_data_i[2:0];
        REG_ELU_ALPHA:   elu_alpha_q   <= cfg_data_i;
        REG_LEAKY_ALPHA: leaky_alpha_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  afu_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .kind_i  (kind_q),
    .valid_i (start && !busy),
    .op_i    (operation_i),
    .x_i     (x_i),
    .valid_o (s1_valid),
    .ctrl_o  (s1_ctrl),
    .t0_o    (s1_t0),
    .t1_o    (s1_t1),
    .frac_o  (s1_frac)
  );

  afu_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ctrl_i  (s1_ctrl),
    .t0_i    (s1_t0),
    .t1_i    (s1_t1),
    .frac_i  (s1_frac),
    .valid_o (s2_valid),
    .ctrl_o  (s2_ctrl),
    .v_o     (s2_v)
  );

  afu_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_q),
    .elu_alpha_i   (elu_alpha_q),
    .leaky_alpha_i (leaky_alpha_q),
    .valid_i       (s2_valid),
    .ctrl_i        (s2_ctrl),
    .v_i           (s2_v),
    .valid_o       (y_valid_o),
    .y_o           (y_o)
  );

endmodule

FILE: sv/afu_checker.sv
// ----------------------------------------------------------------------------
// afu_checker: port-level checks of the activation function unit
// Checks result timing after each transaction and the always-open channels.
// ----------------------------------------------------------------------------
module afu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic y_valid_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 y_valid_o)
    else $error("result missing four cycles after a transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_valid_o |-> $past(start && !busy, 4))
    else $error("result without a matching transaction");

  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind activation_function_unit afu_checker u_afu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .y_valid_o   (y_valid_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
